[rtl/sap_pkg.sv]
package sap_pkg;

  // Flag bits of the ATTRS flags word.
  localparam logic [31:0] FlSize     = 32'h0000_0001;
  localparam logic [31:0] FlUidGid   = 32'h0000_0002;
  localparam logic [31:0] FlPerm     = 32'h0000_0004;
  localparam logic [31:0] FlTimes    = 32'h0000_0008;
  localparam logic [31:0] FlExtended = 32'h8000_0000;

  // Bytes in the size field; every other number is one 32-bit word.
  localparam logic [31:0] SizeBytes = 32'd8;
  localparam logic [31:0] WordBytes = 32'd4;

  typedef enum logic [3:0] {
    PH_FLAGS   = 4'd0,
    PH_SIZE    = 4'd1,
    PH_UID     = 4'd2,
    PH_GID     = 4'd3,
    PH_PERM    = 4'd4,
    PH_ATIME   = 4'd5,
    PH_MTIME   = 4'd6,
    PH_EXTCNT  = 4'd7,
    PH_STRLEN  = 4'd8,
    PH_STRDATA = 4'd9,
    PH_DONE    = 4'd15
  } phase_e;

  typedef enum logic {
    ST_OK        = 1'b0,
    ST_TRUNCATED = 1'b1
  } status_e;

  // One decoded record. The first packed member sits in the highest bits,
  // so the flags word lands in bits 31:0 and the status on top.
  typedef struct packed {
    status_e     status;
    logic [31:0] modify_time;
    logic [31:0] access_time;
    logic [31:0] permissions;
    logic [31:0] group_id;
    logic [31:0] user_id;
    logic [63:0] file_size;
    logic [31:0] attr_flags;
  } result_t;

  localparam int unsigned PayloadBits = $bits(result_t) - 1;

  // First phase at or after p whose field is announced by the flags word.
  function automatic phase_e next_present(phase_e p, logic [31:0] flags);
    phase_e r;
    r = PH_DONE;
    if (p <= PH_EXTCNT && (flags & FlExtended) != '0) r = PH_EXTCNT;
    if (p <= PH_ATIME && (flags & FlTimes) != '0) r = PH_ATIME;
    if (p <= PH_PERM && (flags & FlPerm) != '0) r = PH_PERM;
    if (p <= PH_UID && (flags & FlUidGid) != '0) r = PH_UID;
    if (p <= PH_SIZE && (flags & FlSize) != '0) r = PH_SIZE;
    return r;
  endfunction

endpackage

[rtl/sap_parser.sv]
module sap_parser
  import sap_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       emit_o,
  output result_t    result_o
);

  phase_e      phase_q, phase_d, phase_cur;
  logic [63:0] acc_q, acc_d, acc_shift;
  logic [31:0] cnt_q, cnt_d, cnt_inc, cnt_dec, need, word;
  logic [31:0] ext_q, ext_d, ext_dec;
  logic        pair_q, pair_d;
  logic [31:0] flags_q, flags_d;
  logic [63:0] size_q, size_d;
  logic [31:0] uid_q, uid_d, gid_q, gid_d, perm_q, perm_d;
  logic [31:0] atime_q, atime_d, mtime_q, mtime_d;
  logic        str_done;

  always_comb begin
    phase_cur = (phase_q > PH_STRDATA) ? PH_FLAGS : phase_q;
    acc_shift = {acc_q[55:0], byte_i};
    word      = acc_shift[31:0];
    cnt_inc   = cnt_q + 32'd1;
    cnt_dec   = cnt_q - 32'd1;
    ext_dec   = ext_q - 32'd1;
    need      = (phase_cur == PH_SIZE) ? SizeBytes : WordBytes;

    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    ext_d   = ext_q;
    pair_d  = pair_q;
    flags_d = flags_q;
    size_d  = size_q;
    uid_d   = uid_q;
    gid_d   = gid_q;
    perm_d  = perm_q;
    atime_d = atime_q;
    mtime_d = mtime_q;
    str_done = 1'b0;

    if (fire_i) begin
      phase_d = phase_cur;
      if (phase_cur == PH_STRDATA) begin
        cnt_d = cnt_dec;
        str_done = (cnt_dec == '0);
      end else begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (cnt_inc >= need) begin
          acc_d = '0;
          cnt_d = '0;
          unique case (phase_cur)
            PH_FLAGS: begin
              flags_d = word;
              phase_d = next_present(PH_SIZE, word);
            end
            PH_SIZE: begin
              size_d  = acc_shift;
              phase_d = next_present(PH_UID, flags_q);
            end
            PH_UID: begin
              uid_d   = word;
              phase_d = PH_GID;
            end
            PH_GID: begin
              gid_d   = word;
              phase_d = next_present(PH_PERM, flags_q);
            end
            PH_PERM: begin
              perm_d  = word;
              phase_d = next_present(PH_ATIME, flags_q);
            end
            PH_ATIME: begin
              atime_d = word;
              phase_d = PH_MTIME;
            end
            PH_MTIME: begin
              mtime_d = word;
              phase_d = next_present(PH_EXTCNT, flags_q);
            end
            PH_EXTCNT: begin
              ext_d   = word;
              pair_d  = 1'b0;
              phase_d = (word != '0) ? PH_STRLEN : PH_DONE;
            end
            default: begin
              // String length word: a zero length ends the string at once.
              if (word != '0) begin
                cnt_d   = word;
                phase_d = PH_STRDATA;
              end else begin
                str_done = 1'b1;
              end
            end
          endcase
        end
      end

      if (str_done) begin
        if (!pair_q) begin
          pair_d  = 1'b1;
          phase_d = PH_STRLEN;
        end else begin
          pair_d  = 1'b0;
          ext_d   = ext_dec;
          phase_d = (ext_dec != '0) ? PH_STRLEN : PH_DONE;
        end
      end
    end

    emit_o = fire_i && (phase_d == PH_DONE || last_i);

    result_o.status      = (phase_d == PH_DONE) ? ST_OK : ST_TRUNCATED;
    result_o.attr_flags  = flags_d;
    result_o.file_size   = size_d;
    result_o.user_id     = uid_d;
    result_o.group_id    = gid_d;
    result_o.permissions = perm_d;
    result_o.access_time = atime_d;
    result_o.modify_time = mtime_d;

    // After a result the next byte opens a fresh record.
    if (emit_o) begin
      phase_d = PH_FLAGS;
      acc_d   = '0;
      cnt_d   = '0;
      ext_d   = '0;
      pair_d  = 1'b0;
      flags_d = '0;
      size_d  = '0;
      uid_d   = '0;
      gid_d   = '0;
      perm_d  = '0;
      atime_d = '0;
      mtime_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAGS;
      acc_q   <= '0;
      cnt_q   <= '0;
      ext_q   <= '0;
      pair_q  <= 1'b0;
      flags_q <= '0;
      size_q  <= '0;
      uid_q   <= '0;
      gid_q   <= '0;
      perm_q  <= '0;
      atime_q <= '0;
      mtime_q <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      ext_q   <= ext_d;
      pair_q  <= pair_d;
      flags_q <= flags_d;
      size_q  <= size_d;
      uid_q   <= uid_d;
      gid_q   <= gid_d;
      perm_q  <= perm_d;
      atime_q <= atime_d;
      mtime_q <= mtime_d;
    end
  end

endmodule

[rtl/sftp_attrib_parser.sv]
// SFTP version 3 ATTRS record decoder.
// The slave stream carries the record bytes one per transfer in tdata, with
// tlast marking the last byte of the message. Each byte updates the parse
// state in the cycle it is accepted, so the block takes one byte per clock
// while slave tready is high. When a record completes, or the message ends
// before it completes, one result is loaded into the output register and
// shown on the master stream in the next cycle. tuser gives the status
// (0 complete, 1 truncated) and tdata the decoded fields; absent
// or partly read fields are zero. The byte after a result starts a new
// record. Reset clears the parse state and empties the output register.
// While a result waits and the receiver holds tready low, tready on the
// slave side is low as well; when the receiver takes the result, a new byte
// is accepted in the same cycle, so a steady stream runs at one byte per
// cycle with no bubbles.
module sftp_attrib_parser
  import sap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // data_byte
  input  logic                   s_axis_tlast_i,   // message_end
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // attr_flags, file_size, user_id, group_id, permissions, access_time,
  // modify_time
  output logic [PayloadBits-1:0] m_axis_tdata_o,
  output logic                   m_axis_tuser_o    // status
);

  logic    fire, emit;
  logic    out_valid_q, out_valid_d;
  result_t res, out_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  sap_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .emit_o   (emit),
    .result_o (res)
  );

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q[PayloadBits-1:0];
  assign m_axis_tuser_o  = out_q.status;

  a_emit_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> fire)
    else $error("result produced without an input transfer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_q))
    else $error("waiting result lost or changed");

  a_size_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.attr_flags[0] |-> out_q.file_size == '0)
    else $error("size reported without its flag");

  a_ids_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.attr_flags[1] |-> out_q.user_id == '0 && out_q.group_id == '0)
    else $error("uid or gid reported without their flag");

endmodule
